// ===== hw/rtl/bbp_pkg.sv =====
// bbp_pkg: widths, codes and record types of the block buffer packer.
// Used by every module of the packer; depends on nothing.
package bbp_pkg;

  localparam int SIZE_W   = 12;   // row / column count of a block
  localparam int IDX_W    = 16;   // index buffer use and capacity
  localparam int ELEM_W   = 24;   // element counts and capacity
  localparam int CNT_W    = 16;   // block and buffer counters
  localparam int TOTAL_W  = 40;   // running element total
  localparam int KIND_W   = 2;
  localparam int ERR_W    = 2;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // result kinds
  localparam logic [KIND_W-1:0] K_PLACE = 2'd0;
  localparam logic [KIND_W-1:0] K_CLOSE = 2'd1;
  localparam logic [KIND_W-1:0] K_ERROR = 2'd2;
  localparam logic [KIND_W-1:0] K_FINAL = 2'd3;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_WIDE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FIT  = 2'd2;

  // register indexes (word address)
  localparam logic [1:0] REG_ELEM_CAP = 2'd0;
  localparam logic [1:0] REG_IDX_CAP  = 2'd1;
  localparam logic [1:0] REG_MAX_W    = 2'd2;

  localparam logic [ELEM_W-1:0] ELEM_CAP_RST = 24'd1048576;
  localparam logic [IDX_W-1:0]  IDX_CAP_RST  = 16'd4096;
  localparam logic [SIZE_W-1:0] MAX_W_RST    = 12'd4095;

  localparam logic [CNT_W-1:0] CNT_ONE = {{(CNT_W-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic [ELEM_W-1:0] elem_cap;
    logic [IDX_W-1:0]  idx_cap;
    logic [SIZE_W-1:0] max_w;
  } cfg_t;

  // one classified block, as held in the queue
  typedef struct packed {
    logic [SIZE_W-1:0] row_size;
    logic [SIZE_W-1:0] column_size;
    logic [ELEM_W-1:0] elems;
    logic [ERR_W-1:0]  err;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CNT_W-1:0]   buffer_number;
    logic [IDX_W-1:0]   row_value;
    logic [IDX_W-1:0]   column_value;
    logic [ELEM_W-1:0]  element_value;
    logic [CNT_W-1:0]   count_value;
    logic [ELEM_W-1:0]  block_elements;
    logic [TOTAL_W-1:0] total_elements;
    logic [CNT_W-1:0]   buffer_count;
    logic [ERR_W-1:0]   error_code;
    logic               last_result;
  } res_t;

endpackage

// ===== hw/rtl/bbp_cfg.sv =====
// bbp_cfg: APB-style register file holding the three packing limits.
// Depends on bbp_pkg.
module bbp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bbp_pkg::ADDR_W-1:0]  paddr,
  input  logic [bbp_pkg::DATA_W-1:0]  pwdata,
  output logic [bbp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bbp_pkg::cfg_t               cfg
);
  import bbp_pkg::*;

  logic [ELEM_W-1:0] elem_cap_r;
  logic [IDX_W-1:0]  idx_cap_r;
  logic [SIZE_W-1:0] max_w_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_cap_r <= ELEM_CAP_RST;
      idx_cap_r  <= IDX_CAP_RST;
      max_w_r    <= MAX_W_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ELEM_CAP: elem_cap_r <= pwdata[ELEM_W-1:0];
        REG_IDX_CAP:  idx_cap_r  <= pwdata[IDX_W-1:0];
        REG_MAX_W:    max_w_r    <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ELEM_CAP: prdata = DATA_W'(elem_cap_r);
      REG_IDX_CAP:  prdata = DATA_W'(idx_cap_r);
      REG_MAX_W:    prdata = DATA_W'(max_w_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.elem_cap = elem_cap_r;
  assign cfg.idx_cap  = idx_cap_r;
  assign cfg.max_w    = max_w_r;

endmodule

// ===== hw/rtl/bbp_front.sv =====
// bbp_front: takes input words, forms the element count and sorts out
// blocks that are too wide or too large. Depends on bbp_pkg.
module bbp_front (
  input  logic                        in_valid,
  input  logic [bbp_pkg::SIZE_W-1:0]  in_row_size,
  input  logic [bbp_pkg::SIZE_W-1:0]  in_column_size,
  input  logic                        in_last_block,
  input  bbp_pkg::cfg_t               cfg,
  input  logic                        q_full,
  output logic                        in_stall,
  output logic                        q_push,
  output bbp_pkg::item_t              q_item
);
  import bbp_pkg::*;

  logic [ELEM_W-1:0] elems;
  logic              too_big;

  // 12x12 product always fits the element width
  assign elems = ELEM_W'(in_row_size) * ELEM_W'(in_column_size);

  assign too_big = (elems >= cfg.elem_cap)
                || (IDX_W'(in_row_size) >= cfg.idx_cap)
                || (IDX_W'(in_column_size) >= cfg.idx_cap);

  always_comb begin
    q_item.row_size    = in_row_size;
    q_item.column_size = in_column_size;
    q_item.elems       = elems;
    q_item.last        = in_last_block;
    if (in_column_size > cfg.max_w)
      q_item.err = ERR_WIDE;
    else if (too_big)
      q_item.err = ERR_FIT;
    else
      q_item.err = ERR_NONE;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

endmodule

// ===== hw/rtl/bbp_queue.sv =====
// bbp_queue: short FIFO of classified blocks between front and back end.
// Depends on bbp_pkg.
module bbp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bbp_pkg::item_t  push_item,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output bbp_pkg::item_t  head_item
);
  import bbp_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_pop;

  assign full       = (count_r == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (push)
      mem_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)
        rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bbp_back.sv =====
// bbp_back: buffer state and result sequencer. Walks each queued block
// through its results into the output register, one word per cycle
// unless out_stall holds it. Depends on bbp_pkg.
module bbp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  bbp_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  bbp_pkg::item_t  q_item,
  output logic            q_pop,
  input  logic            out_stall,
  output logic            out_valid,
  output bbp_pkg::res_t   out_res
);
  import bbp_pkg::*;

  typedef enum logic [1:0] {P_FIRST, P_PLACE, P_FCLOSE, P_FINAL} phase_t;
  typedef enum logic [1:0] {S_ERROR, S_CLOSE, S_PLACE, S_FINAL} step_t;

  phase_t             phase_r, phase_nxt;
  logic               flushed_r, flushed_nxt;
  logic [IDX_W-1:0]   row_acc_r, row_acc_nxt;
  logic [IDX_W-1:0]   col_acc_r, col_acc_nxt;
  logic [ELEM_W-1:0]  elem_acc_r, elem_acc_nxt;
  logic [CNT_W-1:0]   blocks_r, blocks_nxt;
  logic [CNT_W-1:0]   cur_buf_r, cur_buf_nxt;
  logic [IDX_W-1:0]   pk_row_r, pk_row_nxt;
  logic [IDX_W-1:0]   pk_col_r, pk_col_nxt;
  logic [ELEM_W-1:0]  pk_elem_r, pk_elem_nxt;
  logic [CNT_W-1:0]   pk_blocks_r, pk_blocks_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               out_valid_r;
  res_t               out_res_r, res;

  step_t              step;
  logic               fire;
  logic               done;
  logic               rebuf;
  logic [IDX_W:0]     row_sum;
  logic [IDX_W:0]     col_sum;
  logic [ELEM_W:0]    elem_sum;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_sat;

  assign fire = q_valid & (~out_valid_r | ~out_stall);

  assign row_sum   = {1'b0, row_acc_r} + (IDX_W+1)'(q_item.row_size);
  assign col_sum   = {1'b0, col_acc_r} + (IDX_W+1)'(q_item.column_size);
  assign elem_sum  = {1'b0, elem_acc_r} + {1'b0, q_item.elems};
  assign total_sum = {1'b0, total_r} + (TOTAL_W+1)'(q_item.elems);
  assign total_sat = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  assign rebuf = (elem_sum >= {1'b0, cfg.elem_cap})
              || (row_sum >= {1'b0, cfg.idx_cap})
              || (col_sum >= {1'b0, cfg.idx_cap});

  // which result this cycle, and where the block goes next
  always_comb begin
    step        = S_PLACE;
    phase_nxt   = P_FIRST;
    done        = 1'b0;
    case (phase_r)
      P_FIRST: begin
        if (q_item.err != ERR_NONE) begin
          step = S_ERROR;
          if (q_item.last) phase_nxt = P_FCLOSE;
          else done = 1'b1;
        end else if (rebuf) begin
          step      = S_CLOSE;
          phase_nxt = P_PLACE;
        end else begin
          step = S_PLACE;
          if (q_item.last) phase_nxt = P_FCLOSE;
          else done = 1'b1;
        end
      end
      P_PLACE: begin
        // buffer already closed for this block: a flush stays silent
        step = S_PLACE;
        if (q_item.last) phase_nxt = P_FINAL;
        else done = 1'b1;
      end
      P_FCLOSE: begin
        step      = S_CLOSE;
        phase_nxt = P_FINAL;
      end
      P_FINAL: begin
        step = S_FINAL;
        done = 1'b1;
      end
      default: begin
        step = S_FINAL;
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    row_acc_nxt   = row_acc_r;
    col_acc_nxt   = col_acc_r;
    elem_acc_nxt  = elem_acc_r;
    blocks_nxt    = blocks_r;
    cur_buf_nxt   = cur_buf_r;
    pk_row_nxt    = pk_row_r;
    pk_col_nxt    = pk_col_r;
    pk_elem_nxt   = pk_elem_r;
    pk_blocks_nxt = pk_blocks_r;
    total_nxt     = total_r;
    flushed_nxt   = flushed_r;

    res                = '0;
    res.block_elements = q_item.elems;
    res.total_elements = total_r;
    res.buffer_count   = cur_buf_r;
    res.buffer_number  = cur_buf_r;
    res.error_code     = ERR_NONE;
    res.last_result    = done;

    case (step)
      S_ERROR: begin
        res.kind       = K_ERROR;
        res.error_code = q_item.err;
      end
      S_CLOSE: begin
        res.kind          = K_CLOSE;
        res.row_value     = row_acc_r;
        res.column_value  = col_acc_r;
        res.element_value = elem_acc_r;
        res.count_value   = blocks_r;
        res.buffer_count  = cur_buf_r + CNT_ONE;
        pk_row_nxt    = (row_acc_r > pk_row_r) ? row_acc_r : pk_row_r;
        pk_col_nxt    = (col_acc_r > pk_col_r) ? col_acc_r : pk_col_r;
        pk_elem_nxt   = (elem_acc_r > pk_elem_r) ? elem_acc_r : pk_elem_r;
        pk_blocks_nxt = (blocks_r > pk_blocks_r) ? blocks_r : pk_blocks_r;
        cur_buf_nxt   = cur_buf_r + CNT_ONE;
        row_acc_nxt   = '0;
        col_acc_nxt   = '0;
        elem_acc_nxt  = '0;
        blocks_nxt    = '0;
        if (phase_r == P_FCLOSE) flushed_nxt = 1'b1;
      end
      S_PLACE: begin
        res.kind           = K_PLACE;
        res.row_value      = row_acc_r;
        res.column_value   = col_acc_r;
        res.element_value  = elem_acc_r;
        res.total_elements = total_sat;
        total_nxt    = total_sat;
        row_acc_nxt  = row_sum[IDX_W-1:0];
        col_acc_nxt  = col_sum[IDX_W-1:0];
        elem_acc_nxt = elem_sum[ELEM_W-1:0];
        blocks_nxt   = (blocks_r == '1) ? blocks_r : blocks_r + CNT_ONE;
      end
      S_FINAL: begin
        // a silently flushed buffer still counts toward the maxima;
        // after a reported flush the accumulators are already zero
        pk_row_nxt    = (row_acc_r > pk_row_r) ? row_acc_r : pk_row_r;
        pk_col_nxt    = (col_acc_r > pk_col_r) ? col_acc_r : pk_col_r;
        pk_elem_nxt   = (elem_acc_r > pk_elem_r) ? elem_acc_r : pk_elem_r;
        pk_blocks_nxt = (blocks_r > pk_blocks_r) ? blocks_r : pk_blocks_r;
        res.kind          = K_FINAL;
        res.buffer_number = flushed_r ? cur_buf_r - CNT_ONE : cur_buf_r;
        res.buffer_count  = flushed_r ? cur_buf_r : cur_buf_r + CNT_ONE;
        res.row_value     = pk_row_nxt;
        res.column_value  = pk_col_nxt;
        res.element_value = pk_elem_nxt;
        res.count_value   = pk_blocks_nxt;
        row_acc_nxt   = '0;
        col_acc_nxt   = '0;
        elem_acc_nxt  = '0;
        blocks_nxt    = '0;
        cur_buf_nxt   = '0;
        pk_row_nxt    = '0;
        pk_col_nxt    = '0;
        pk_elem_nxt   = '0;
        pk_blocks_nxt = '0;
        total_nxt     = '0;
      end
      default: ;
    endcase

    if (done) flushed_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= P_FIRST;
      flushed_r   <= 1'b0;
      row_acc_r   <= '0;
      col_acc_r   <= '0;
      elem_acc_r  <= '0;
      blocks_r    <= '0;
      cur_buf_r   <= '0;
      pk_row_r    <= '0;
      pk_col_r    <= '0;
      pk_elem_r   <= '0;
      pk_blocks_r <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r     <= phase_nxt;
        flushed_r   <= flushed_nxt;
        row_acc_r   <= row_acc_nxt;
        col_acc_r   <= col_acc_nxt;
        elem_acc_r  <= elem_acc_nxt;
        blocks_r    <= blocks_nxt;
        cur_buf_r   <= cur_buf_nxt;
        pk_row_r    <= pk_row_nxt;
        pk_col_r    <= pk_col_nxt;
        pk_elem_r   <= pk_elem_nxt;
        pk_blocks_r <= pk_blocks_nxt;
        total_r     <= total_nxt;
        out_valid_r <= 1'b1;
        out_res_r   <= res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign q_pop     = fire & done;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== hw/rtl/block_buffer_packer_top.sv =====
// block_buffer_packer_top: next-fit packer of dense blocks into buffers.
// Instantiates bbp_cfg, bbp_front, bbp_queue and bbp_back; uses bbp_pkg.
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid / in_stall  row_size, column_size, last_block
//   out_*        output     out_valid/out_stall  kind .. last_result (11 fields)
//   APB          input      psel/penable/pready  paddr, pwdata, prdata
//
// A block causes 1 to 3 result words; the back-end sequencer emits one word
// per cycle unless out_stall holds it, so single-result blocks stream at one
// per cycle when unstalled. The first result word passes the queue, then the output register.
// rst_n is synchronous, active low: clears buffer state, queue, output stage
// and loads the limit registers with their defaults.
// out_stall holds the output register and the sequencer; a 4-word queue
// lets the front keep accepting until it fills, then in_stall rises.
module block_buffer_packer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bbp_pkg::SIZE_W-1:0]   in_row_size,
  input  logic [bbp_pkg::SIZE_W-1:0]   in_column_size,
  input  logic                         in_last_block,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bbp_pkg::KIND_W-1:0]   out_kind,
  output logic [bbp_pkg::CNT_W-1:0]    out_buffer_number,
  output logic [bbp_pkg::IDX_W-1:0]    out_row_value,
  output logic [bbp_pkg::IDX_W-1:0]    out_column_value,
  output logic [bbp_pkg::ELEM_W-1:0]   out_element_value,
  output logic [bbp_pkg::CNT_W-1:0]    out_count_value,
  output logic [bbp_pkg::ELEM_W-1:0]   out_block_elements,
  output logic [bbp_pkg::TOTAL_W-1:0]  out_total_elements,
  output logic [bbp_pkg::CNT_W-1:0]    out_buffer_count,
  output logic [bbp_pkg::ERR_W-1:0]    out_error_code,
  output logic                         out_last_result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bbp_pkg::ADDR_W-1:0]   paddr,
  input  logic [bbp_pkg::DATA_W-1:0]   pwdata,
  output logic [bbp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import bbp_pkg::*;

  cfg_t  cfg;
  item_t push_item;
  item_t head_item;
  res_t  res;
  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  head_valid;

  bbp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bbp_front u_front (
    .in_valid       (in_valid),
    .in_row_size    (in_row_size),
    .in_column_size (in_column_size),
    .in_last_block  (in_last_block),
    .cfg            (cfg),
    .q_full         (q_full),
    .in_stall       (in_stall),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  bbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  bbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (head_valid),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_kind           = res.kind;
  assign out_buffer_number  = res.buffer_number;
  assign out_row_value      = res.row_value;
  assign out_column_value   = res.column_value;
  assign out_element_value  = res.element_value;
  assign out_count_value    = res.count_value;
  assign out_block_elements = res.block_elements;
  assign out_total_elements = res.total_elements;
  assign out_buffer_count   = res.buffer_count;
  assign out_error_code     = res.error_code;
  assign out_last_result    = res.last_result;

  // totals always end the block's results
  a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == K_FINAL) |-> out_last_result)
    else $error("final totals word not marked last");

  a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == K_ERROR) |->
      (out_row_value == '0 && out_column_value == '0 &&
       out_element_value == '0 && out_count_value == '0 &&
       out_error_code != ERR_NONE))
    else $error("error word carries buffer values");

  a_place_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == K_PLACE) |->
      (out_error_code == ERR_NONE && out_count_value == '0))
    else $error("placement word with count or error");

  // a word pulled from the queue must leave a result behind
  a_pop_makes_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_last_result))
    else $error("block retired without a last word");

endmodule

// ===== tb/block_buffer_packer_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for block_buffer_packer_top: next-fit buffer plan predictor,
// random idle bursts on both channels, APB setup of the three limit registers.
// Depends on bbp_pkg and block_buffer_packer_top only.
module block_buffer_packer_top_tb;
  import bbp_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int PHASE_BLOCKS = 75;

  // Predicts the result words of each accepted block and checks them in order.
  class packing_plan;
    logic [ELEM_W-1:0]  elem_cap;
    logic [IDX_W-1:0]   idx_cap;
    logic [SIZE_W-1:0]  max_w;
    logic [IDX_W-1:0]   row_acc, col_acc, peak_row, peak_col;
    logic [ELEM_W-1:0]  elem_acc, peak_elem;
    logic [CNT_W-1:0]   blk_cnt, buf_num, peak_blk;
    logic [TOTAL_W-1:0] elem_total;
    res_t               planned_words[$];
    int                 mismatches;

    function new();
      mismatches = 0;
      elem_cap = ELEM_CAP_RST;
      idx_cap = IDX_CAP_RST;
      max_w = MAX_W_RST;
      clear_list();
    endfunction

    function void clear_list();
      row_acc = '0; col_acc = '0; elem_acc = '0; blk_cnt = '0; buf_num = '0;
      peak_row = '0; peak_col = '0; peak_elem = '0; peak_blk = '0; elem_total = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_ELEM_CAP: elem_cap = v[ELEM_W-1:0];
        REG_IDX_CAP:  idx_cap = v[IDX_W-1:0];
        REG_MAX_W:    max_w = v[SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    function void push(logic [KIND_W-1:0] kind, logic [CNT_W-1:0] bufn,
                       logic [IDX_W-1:0] rv, logic [IDX_W-1:0] cv,
                       logic [ELEM_W-1:0] ev, logic [CNT_W-1:0] cnt,
                       logic [ELEM_W-1:0] be, logic [ERR_W-1:0] err);
      res_t w;
      w.kind = kind;
      w.buffer_number = bufn;
      w.row_value = rv;
      w.column_value = cv;
      w.element_value = ev;
      w.count_value = cnt;
      w.block_elements = be;
      w.total_elements = elem_total;
      w.buffer_count = buf_num;
      w.error_code = err;
      w.last_result = 1'b0;
      planned_words = {planned_words, w};
    endfunction

    function void close_buffer(bit report, logic [ELEM_W-1:0] be);
      logic [IDX_W-1:0]  r, c;
      logic [ELEM_W-1:0] e;
      logic [CNT_W-1:0]  b, num;
      r = row_acc; c = col_acc; e = elem_acc; b = blk_cnt; num = buf_num;
      if (r > peak_row) peak_row = r;
      if (c > peak_col) peak_col = c;
      if (e > peak_elem) peak_elem = e;
      if (b > peak_blk) peak_blk = b;
      buf_num++;
      row_acc = '0; col_acc = '0; elem_acc = '0; blk_cnt = '0;
      if (report) push(K_CLOSE, num, r, c, e, b, be, ERR_NONE);
    endfunction

    function void note_block(logic [SIZE_W-1:0] r, logic [SIZE_W-1:0] c, logic is_last);
      logic [ELEM_W-1:0]  elems;
      logic [ERR_W-1:0]   err;
      logic [TOTAL_W:0]   sum;
      logic [CNT_W-1:0]   final_buf;
      bit                 rebuf;
      elems = r * c;
      rebuf = 1'b0;
      err = ERR_NONE;
      if (c > max_w) err = ERR_WIDE;
      else if (elems >= elem_cap || r >= idx_cap || c >= idx_cap) err = ERR_FIT;
      if (err != ERR_NONE) begin
        push(K_ERROR, buf_num, '0, '0, '0, '0, elems, err);
      end else begin
        rebuf = ({1'b0, elem_acc} + elems >= {1'b0, elem_cap}) ||
                ({1'b0, row_acc} + r >= {1'b0, idx_cap}) ||
                ({1'b0, col_acc} + c >= {1'b0, idx_cap});
        if (rebuf) close_buffer(1'b1, elems);
        sum = {1'b0, elem_total} + elems;
        elem_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        push(K_PLACE, buf_num, row_acc, col_acc, elem_acc, '0, elems, ERR_NONE);
        row_acc += r;
        col_acc += c;
        elem_acc += elems;
        if (blk_cnt != '1) blk_cnt++;
      end
      if (is_last) begin
        // a last block that opened a fresh buffer needs no close word for it
        final_buf = buf_num;
        close_buffer(!rebuf, elems);
        push(K_FINAL, final_buf, peak_row, peak_col, peak_elem, peak_blk, elems, ERR_NONE);
        clear_list();
      end
      planned_words[planned_words.size() - 1].last_result = 1'b1;
    endfunction

    function int differs(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (planned_words.size() == 0) begin
        $error("result word with nothing pending: kind %0d", got.kind);
        mismatches++;
        return;
      end
      want = planned_words.pop_front();
      mismatches += differs("kind", want.kind, got.kind)
                  + differs("buffer_number", want.buffer_number, got.buffer_number)
                  + differs("row_value", want.row_value, got.row_value)
                  + differs("column_value", want.column_value, got.column_value)
                  + differs("element_value", want.element_value, got.element_value)
                  + differs("count_value", want.count_value, got.count_value)
                  + differs("block_elements", want.block_elements, got.block_elements)
                  + differs("total_elements", want.total_elements, got.total_elements)
                  + differs("buffer_count", want.buffer_count, got.buffer_count)
                  + differs("error_code", want.error_code, got.error_code)
                  + differs("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [SIZE_W-1:0]   in_row_size;
  logic [SIZE_W-1:0]   in_column_size;
  logic                in_last_block;
  logic                out_valid;
  logic                out_stall;
  logic [KIND_W-1:0]   out_kind;
  logic [CNT_W-1:0]    out_buffer_number;
  logic [IDX_W-1:0]    out_row_value;
  logic [IDX_W-1:0]    out_column_value;
  logic [ELEM_W-1:0]   out_element_value;
  logic [CNT_W-1:0]    out_count_value;
  logic [ELEM_W-1:0]   out_block_elements;
  logic [TOTAL_W-1:0]  out_total_elements;
  logic [CNT_W-1:0]    out_buffer_count;
  logic [ERR_W-1:0]    out_error_code;
  logic                out_last_result;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  packing_plan plan;
  bit          idle_on = 1'b1;

  block_buffer_packer_top uut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side back-pressure in short bursts
  initial begin : result_stall
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (burst == 0 && idle_on && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 4);
      out_stall <= (burst != 0);
      if (burst != 0) burst--;
    end
  end

  always @(posedge clk) begin : result_monitor
    res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = out_kind;
      got.buffer_number = out_buffer_number;
      got.row_value = out_row_value;
      got.column_value = out_column_value;
      got.element_value = out_element_value;
      got.count_value = out_count_value;
      got.block_elements = out_block_elements;
      got.total_elements = out_total_elements;
      got.buffer_count = out_buffer_count;
      got.error_code = out_error_code;
      got.last_result = out_last_result;
      plan.check_word(got);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("block_buffer_packer_top_tb: done, errors");
        $finish;
      end
    end
  end

  // entered and left at a falling edge with no pending assignment
  task automatic send_block(logic [SIZE_W-1:0] r, logic [SIZE_W-1:0] c, logic is_last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_row_size <= r;
    in_column_size <= c;
    in_last_block <= is_last;
    do @(posedge clk); while (in_stall);
    plan.note_block(r, c, is_last);
    @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [1:0] idx,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk) begin
      psel <= 1'b0;
      penable <= 1'b0;
    end
    @(negedge clk);
  endtask

  task automatic program_reg(logic [1:0] idx, logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] rd;
    apb_xfer(1'b1, idx, v, rd);
    plan.set_reg(idx, v);
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== v) begin
      $error("register %0d readback: expected 0x%0h, got 0x%0h", idx, v, rd);
      plan.mismatches++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (plan.planned_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(int ecap, int icap, int mw);
    drain();
    program_reg(REG_ELEM_CAP, ecap);
    program_reg(REG_IDX_CAP, icap);
    program_reg(REG_MAX_W, mw);
  endtask

  initial begin : stimulus
    int dim_hi, area, ecap, icap, mw, n, len;
    logic [SIZE_W-1:0] r, c;
    logic is_last;
    plan = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_row_size = '0;
    in_column_size = '0;
    in_last_block = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // default limits: edges of the sizes, rebuffering, the fit error, flush cases
    send_block(0, 0, 0);
    send_block(1, 1, 0);
    send_block(4095, 1, 0);
    send_block(1, 4095, 0);
    send_block(4095, 4095, 0);
    send_block(1024, 1024, 0);
    send_block(1023, 1024, 0);
    send_block(16, 16, 0);
    send_block(0, 4095, 1);
    send_block(5, 5, 1);
    send_block(100, 100, 0);
    send_block(4000, 10, 1);   // last block opens a new buffer
    send_block(4095, 4095, 1); // error on the last block flushes an empty buffer
    send_block(0, 0, 1);

    // tightest limits: only 0x0 blocks fit, any nonzero column is too wide
    configure(1, 1, 0);
    send_block(0, 0, 0);
    send_block(3, 0, 0);
    send_block(0, 1, 0);
    send_block(0, 0, 0);
    send_block(0, 4095, 1);

    // loosest limits: full-size blocks fit one per buffer
    configure(24'hFFFFFF, 16'hFFFF, 12'hFFF);
    send_block(4095, 4095, 0);
    send_block(4095, 4095, 0);
    send_block(1, 1, 0);
    send_block(4095, 4095, 1);

    for (int ph = 0; ph < 6; ph++) begin
      dim_hi = (1 << $urandom_range(4, 12)) - 1;
      area = dim_hi * dim_hi;
      ecap = $urandom_range(area / 4 + 1, area * 4);
      if (ecap > 24'hFFFFFF) ecap = 24'hFFFFFF;
      icap = $urandom_range(dim_hi / 2 + 1, dim_hi * 5);
      if (icap > 16'hFFFF) icap = 16'hFFFF;
      mw = $urandom_range(dim_hi * 3 / 4, 4095);
      configure(ecap, icap, mw);
      if (ph == 5) idle_on = 1'b0;
      n = 0;
      while (n < PHASE_BLOCKS) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len && n < PHASE_BLOCKS; i++) begin
          case ($urandom_range(0, 9))
            0: begin
              r = SIZE_W'($urandom);
              c = SIZE_W'($urandom);
            end
            1: begin
              r = '0;
              c = SIZE_W'($urandom_range(0, dim_hi));
            end
            2: begin
              r = SIZE_W'($urandom_range(0, dim_hi));
              c = SIZE_W'(mw + $urandom_range(0, 2));   // straddles the width limit
            end
            default: begin
              r = SIZE_W'($urandom_range(0, dim_hi));
              c = SIZE_W'($urandom_range(0, dim_hi));
            end
          endcase
          is_last = (i == len - 1);
          if ($urandom_range(0, 19) == 0) is_last = !is_last;
          send_block(r, c, is_last);
          n++;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (plan.mismatches == 0) $display("block_buffer_packer_top_tb: done, clean");
    else $display("block_buffer_packer_top_tb: done, errors");
    $finish;
  end

endmodule
